// ===== rtl/core/gdiq_pkg.sv =====
// ----------------------------------------------------------------------------
// gdiq_pkg: shared definitions of the debounced interrupt qualifier
// Field widths, register indexes, trigger mode codes and the settings
// structure that the register block hands to the qualifier.
// ----------------------------------------------------------------------------
package gdiq_pkg;

  localparam int unsigned TICK_MS = 10;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned DEB_W   = 16;
  localparam int unsigned TICKS_W = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS  = 1'd1;

  localparam logic [MODE_W-1:0] MODE_NONE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FALLING = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RISING  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BOTH    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HIGH    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_LOW     = 3'd5;

  // Division of the debounce time by TICK_MS is done with an exact reciprocal.
  localparam int unsigned DIV_SHIFT = DEB_W + $clog2(TICK_MS);
  localparam longint unsigned DIV_RECIP =
    ((64'd1 << DIV_SHIFT) + TICK_MS - 1) / TICK_MS;
  localparam int unsigned PROD_W = DEB_W + DIV_SHIFT + 1;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic               deb_en;
    logic [TICKS_W-1:0] reload;
  } gdiq_cfg_t;

endpackage

// ===== rtl/core/gdiq_cfg.sv =====
// ----------------------------------------------------------------------------
// gdiq_cfg: configuration registers
// Holds the trigger mode and the debounce setting, the latter kept as the
// number of ticks that one arming of the debounce timer loads.
// ----------------------------------------------------------------------------
module gdiq_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [gdiq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gdiq_pkg::CFG_W-1:0]      cfg_data,
  output gdiq_pkg::gdiq_cfg_t             cfg
);
  import gdiq_pkg::*;

  logic [PROD_W-1:0]  prod;
  logic [TICKS_W-1:0] quot;
  logic [TICKS_W-1:0] reload_next;

  assign prod = PROD_W'(cfg_data[DEB_W-1:0]) * PROD_W'(DIV_RECIP);
  assign quot = prod[DIV_SHIFT +: TICKS_W];
  assign reload_next = (quot == '0) ? TICKS_W'(1) : quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= MODE_NONE;
      cfg.deb_en <= 1'b0;
      cfg.reload <= TICKS_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TRIGGER_MODE: cfg.mode <= cfg_data[MODE_W-1:0];
        REG_DEBOUNCE_MS: begin
          cfg.deb_en <= (cfg_data[DEB_W-1:0] != '0);
          cfg.reload <= reload_next;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/gdiq_qual.sv =====
// ----------------------------------------------------------------------------
// gdiq_qual: trigger detection and debounce timer
// Updates the pin history and the debounce timer for one request and tells
// whether that request raises a qualified event.
// ----------------------------------------------------------------------------
module gdiq_qual (
  input  logic                clk,
  input  logic                rst,
  input  gdiq_pkg::gdiq_cfg_t cfg,
  input  logic                fire,
  input  logic                level,
  input  logic                tick,
  output logic                emit
);
  import gdiq_pkg::*;

  logic               previous_level;
  logic               waiting_flag;
  logic               expected_level;
  logic [TICKS_W-1:0] ticks_left;

  logic               waiting_flag_next;
  logic               expected_level_next;
  logic [TICKS_W-1:0] ticks_left_next;
  logic [TICKS_W-1:0] ticks_dec;
  logic               trig;

  always_comb begin
    case (cfg.mode)
      MODE_FALLING: trig = previous_level & ~level;
      MODE_RISING:  trig = ~previous_level & level;
      MODE_BOTH:    trig = previous_level ^ level;
      MODE_HIGH:    trig = level;
      MODE_LOW:     trig = ~level;
      default:      trig = 1'b0;
    endcase
  end

  assign ticks_dec = (ticks_left != '0) ? ticks_left - TICKS_W'(1) : ticks_left;

  always_comb begin
    waiting_flag_next   = waiting_flag;
    expected_level_next = expected_level;
    ticks_left_next     = ticks_left;
    emit                = 1'b0;
    if (waiting_flag && tick) begin
      ticks_left_next = ticks_dec;
      if (ticks_dec == '0) begin
        if (level == expected_level) begin
          emit = 1'b1;
          if (cfg.mode == MODE_BOTH) begin
            expected_level_next = ~expected_level;
          end
        end
        waiting_flag_next = 1'b0;
      end
    end
    if (!waiting_flag_next && trig) begin
      if (cfg.deb_en) begin
        waiting_flag_next   = 1'b1;
        expected_level_next = level;
        ticks_left_next     = cfg.reload;
      end else begin
        emit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= 1'b0;
      waiting_flag   <= 1'b0;
      expected_level <= 1'b0;
      ticks_left     <= '0;
    end else if (fire) begin
      previous_level <= level;
      waiting_flag   <= waiting_flag_next;
      expected_level <= expected_level_next;
      ticks_left     <= ticks_left_next;
    end
  end

endmodule

// ===== rtl/core/gpio_debounced_interrupt_qualifier_top.sv =====
// ----------------------------------------------------------------------------
// gpio_debounced_interrupt_qualifier_top: debounced pin interrupt qualifier
// Each input request carries one sampled pin level and a tick flag. The
// block detects the trigger chosen by trigger_mode and, when debounce_ms is
// nonzero, confirms it after max(1, debounce_ms / TICK_MS) ticks.
// A request enters on in_valid/in_ready and is held in an input register.
// Once the output register can take it, the request updates the pin
// history and the debounce timer; if it raises an event, event_level is
// loaded into the output register and shown on out_valid/out_ready.
// Requests that raise no event give no output. One request is taken every
// cycle while the receiver does not stall; the rate is set by the state
// update between the input and output registers. When the receiver stalls
// with an event pending, the input register holds one more request and
// in_ready falls. Configuration writes on cfg_write/cfg_index/cfg_data are
// registered; the debounce tick count is computed from the write data. Reset
// clears valid and qualifier state, selects no trigger, disables debouncing.
// ----------------------------------------------------------------------------
module gpio_debounced_interrupt_qualifier_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [gdiq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gdiq_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            pin_level,
  input  logic                            tick,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            event_level
);
  import gdiq_pkg::*;

  gdiq_cfg_t cfg;
  logic      s1_valid;
  logic      s1_level;
  logic      s1_tick;
  logic      s1_fire;
  logic      emit;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  gdiq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gdiq_qual u_qual (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .fire  (s1_fire),
    .level (s1_level),
    .tick  (s1_tick),
    .emit  (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_level <= pin_level;
      s1_tick  <= tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      event_level <= s1_level;
    end
  end

endmodule
